### rtl/core/pjsd_pkg.sv
// pjsd_pkg: shared constants and command/status types for the pair dissimilarity block
// no dependencies

package pjsd_pkg;

	localparam int AREA_BITS_DEF = 20;
	localparam int LOG_FRAC_BITS_DEF = 16;
	localparam int TOTAL_BITS = 28;
	localparam int OUT_FRAC_BITS = 16;
	localparam int OUT_BITS = 17;
	localparam int ACC_BITS = 64;
	localparam int MANT_BITS = 33;
	localparam logic [OUT_BITS-1:0] ONE_OUT = 17'd65536;

	typedef enum logic [1:0] {
		SEL_SUM = 2'd0,
		SEL_I   = 2'd1,
		SEL_J   = 2'd2
	} term_sel_t;

	typedef struct packed {
		logic      load;
		logic      log_start;
		logic      log_arg_s;
		term_sel_t sel;
		logic      acc_add;
		logic      acc_sub;
		logic      div_start;
		logic      acc_clear;
	} pjsd_cmd_t;

	typedef struct packed {
		logic log_done;
		logic div_done;
		logic last;
	} pjsd_sts_t;

endpackage

### rtl/core/pjsd_log2.sv
// pjsd_log2: iterative fixed point log2, one squaring per cycle
// depends on pjsd_pkg

module pjsd_log2
	import pjsd_pkg::*;
#(
	parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF,
	parameter int X_BITS = TOTAL_BITS + 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [X_BITS-1:0]                     x,
	output logic                                  done,
	output logic [LOG_FRAC_BITS+$clog2(X_BITS)-1:0] result
);

	localparam int NW = $clog2(X_BITS);
	localparam int KW = $clog2(LOG_FRAC_BITS + 1);

	logic [MANT_BITS-1:0]     y_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic [NW-1:0]            n_q;
	logic [KW-1:0]            k_q;
	logic                     busy_q;
	logic                     zero_q;

	logic [NW-1:0]            n_c;
	logic [MANT_BITS-1:0]     y_init;
	logic [2*MANT_BITS-1:0]   sq;
	logic [MANT_BITS-1:0]     ysq;

	always_comb begin
		n_c = '0;
		for (int b = 0; b < X_BITS; b++) begin
			if (x[b]) n_c = NW'(b);
		end
	end

	always_comb begin
		if (int'(n_c) <= 31) begin
			y_init = MANT_BITS'({32'd0, x} << (31 - int'(n_c)));
		end else begin
			y_init = MANT_BITS'(x >> (int'(n_c) - 31));
		end
	end

	assign sq  = y_q * y_q;
	assign ysq = MANT_BITS'(sq >> 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			k_q    <= '0;
			n_q    <= '0;
			zero_q <= 1'b1;
			y_q    <= '0;
			frac_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				n_q    <= n_c;
				zero_q <= (x == '0);
				y_q    <= y_init;
				frac_q <= '0;
			end else if (busy_q) begin
				if (ysq[32]) begin
					y_q    <= ysq >> 1;
					frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b1};
				end else begin
					y_q    <= ysq;
					frac_q <= {frac_q[LOG_FRAC_BITS-2:0], 1'b0};
				end
				k_q <= k_q + 1'b1;
				if (k_q == KW'(LOG_FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign result = zero_q ? '0 : {n_q, frac_q};

endmodule

### rtl/core/pjsd_div.sv
// pjsd_div: radix-2 restoring divider of a 64 bit dividend by a 29 bit divisor
// depends on pjsd_pkg

module pjsd_div
	import pjsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [ACC_BITS-1:0]    dividend,
	input  logic [TOTAL_BITS:0]    divisor,
	output logic                   done,
	output logic [ACC_BITS-1:0]    quotient
);

	logic [TOTAL_BITS+1:0] rem_q;
	logic [TOTAL_BITS:0]   dsr_q;
	logic [6:0]            cnt_q;
	logic                  busy_q;
	logic [TOTAL_BITS+1:0] shifted;

	assign shifted = {rem_q[TOTAL_BITS:0], quotient[ACC_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done     <= 1'b0;
			cnt_q    <= '0;
			rem_q    <= '0;
			dsr_q    <= '0;
			quotient <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				rem_q    <= '0;
				dsr_q    <= divisor;
				quotient <= dividend;
			end else if (busy_q) begin
				if (shifted >= {1'b0, dsr_q}) begin
					rem_q    <= shifted - {1'b0, dsr_q};
					quotient <= {quotient[ACC_BITS-2:0], 1'b1};
				end else begin
					rem_q    <= shifted;
					quotient <= {quotient[ACC_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 7'(ACC_BITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/pjsd_datapath.sv
// pjsd_datapath: operand registers, log unit, term multiply, accumulator, divide, clamp
// depends on pjsd_pkg, pjsd_log2, pjsd_div

module pjsd_datapath
	import pjsd_pkg::*;
#(
	parameter int AREA_BITS = AREA_BITS_DEF,
	parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pjsd_cmd_t             cmd,
	output pjsd_sts_t             sts,
	input  logic [AREA_BITS-1:0]  area_i,
	input  logic [AREA_BITS-1:0]  area_j,
	input  logic [TOTAL_BITS-1:0] total_i,
	input  logic [TOTAL_BITS-1:0] total_j,
	input  logic                  last,
	output logic [OUT_BITS-1:0]   result
);

	localparam int XW = (AREA_BITS > TOTAL_BITS) ? AREA_BITS + 1 : TOTAL_BITS + 1;
	localparam int LW = LOG_FRAC_BITS + $clog2(XW);

	logic [AREA_BITS:0]    ai_q, aj_q, aij_q;
	logic [TOTAL_BITS:0]   ti_q, tj_q, tij_q;
	logic                  last_q;
	logic [LW-1:0]         la_q;
	logic [XW-1:0]         log_x;
	logic [LW-1:0]         log_r;
	logic [AREA_BITS:0]    a_sel;
	logic [TOTAL_BITS:0]   s_sel;
	logic signed [LW:0]    diff;
	logic signed [ACC_BITS-1:0] term;
	logic [ACC_BITS-1:0]   acc_q;
	logic [ACC_BITS-1:0]   quo;
	logic                  div_done;
	logic [ACC_BITS-1:0]   res_w;

	always_comb begin
		case (cmd.sel)
			SEL_I: begin
				a_sel = ai_q;
				s_sel = ti_q;
			end
			SEL_J: begin
				a_sel = aj_q;
				s_sel = tj_q;
			end
			default: begin
				a_sel = aij_q;
				s_sel = tij_q;
			end
		endcase
	end

	assign log_x = cmd.log_arg_s ? XW'(s_sel) : XW'(a_sel);

	pjsd_log2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS), .X_BITS(XW)) u_log (
		.clk(clk), .arst_n(arst_n), .start(cmd.log_start), .x(log_x),
		.done(sts.log_done), .result(log_r)
	);

	assign diff = $signed({1'b0, la_q}) - $signed({1'b0, log_r});
	assign term = (a_sel == '0) ? '0 :
		ACC_BITS'($signed({1'b0, a_sel}) * diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + term;
		end else if (cmd.acc_sub) begin
			acc_q <= acc_q - term;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ai_q   <= {1'b0, area_i};
			aj_q   <= {1'b0, area_j};
			aij_q  <= (AREA_BITS+1)'(area_i) + (AREA_BITS+1)'(area_j);
			ti_q   <= {1'b0, total_i};
			tj_q   <= {1'b0, total_j};
			tij_q  <= (TOTAL_BITS+1)'(total_i) + (TOTAL_BITS+1)'(total_j);
			last_q <= last;
		end
		if (sts.log_done && cmd.log_arg_s) la_q <= log_r;
	end

	pjsd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(acc_q),
		.divisor(tij_q), .done(div_done), .quotient(quo)
	);

	always_comb begin
		if (LOG_FRAC_BITS >= OUT_FRAC_BITS) begin
			res_w = quo >> (LOG_FRAC_BITS - OUT_FRAC_BITS);
		end else if (quo >= (64'd1 << 40)) begin
			res_w = ACC_BITS'(ONE_OUT);
		end else begin
			res_w = quo << (OUT_FRAC_BITS - LOG_FRAC_BITS);
		end
		if (tij_q == '0 || acc_q[ACC_BITS-1] || acc_q == '0) begin
			result = '0;
		end else if (res_w > ACC_BITS'(ONE_OUT)) begin
			result = ONE_OUT;
		end else begin
			result = OUT_BITS'(res_w);
		end
	end

	assign sts.div_done = div_done;
	assign sts.last     = last_q;

endmodule

### rtl/core/pjsd_ctrl.sv
// pjsd_ctrl: sequencer for three terms per item and the final divide
// depends on pjsd_pkg

module pjsd_ctrl
	import pjsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output pjsd_cmd_t cmd,
	input  pjsd_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOGA, ST_LOGS, ST_NEXT, ST_DIV, ST_OUT
	} state_t;

	state_t    state_q;
	term_sel_t sel_q;
	logic      div_go_q;

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		cmd.log_arg_s = (state_q == ST_LOGA);
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.div_start = div_go_q;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		if (state_q == ST_NEXT) cmd.log_start = 1'b1;
		if (state_q == ST_LOGA && sts.log_done) cmd.log_start = 1'b1;
		if (state_q == ST_LOGS && sts.log_done) begin
			cmd.acc_sub = (sel_q == SEL_SUM);
			cmd.acc_add = (sel_q != SEL_SUM);
		end
		if (state_q == ST_OUT && !out_stall) cmd.acc_clear = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sel_q    <= SEL_SUM;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sel_q   <= SEL_SUM;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: state_q <= ST_LOGA;
				ST_LOGA: if (sts.log_done) state_q <= ST_LOGS;
				ST_LOGS: begin
					if (sts.log_done) begin
						if (sel_q == SEL_J) begin
							if (sts.last) begin
								state_q  <= ST_DIV;
								div_go_q <= 1'b1;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							sel_q   <= (sel_q == SEL_SUM) ? SEL_I : SEL_J;
							state_q <= ST_NEXT;
						end
					end
				end
				ST_DIV: if (sts.div_done) state_q <= ST_OUT;
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/polygon_pair_js_dissimilarity.sv
// polygon_pair_js_dissimilarity: top level, joins controller and datapath
// depends on pjsd_pkg, pjsd_ctrl, pjsd_datapath
//
// channel  direction  handshake              payload
// in       in         in_valid / in_stall    area_i area_j total_i total_j last
// out      out        out_valid / out_stall  dissimilarity
//
// one item takes six log2 passes, one launch state (ST_NEXT) per term and the accepting
// idle state; the shared log2 unit sets how long an item takes
// a last item adds the radix-2 divide, then holds until the transfer out
// reset clears the accumulator and returns the sequencer to idle
// input stalls from acceptance until the item, or its result, is finished

module polygon_pair_js_dissimilarity
	import pjsd_pkg::*;
#(
	parameter int AREA_BITS = AREA_BITS_DEF,
	parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [AREA_BITS-1:0]  area_i,
	input  logic [AREA_BITS-1:0]  area_j,
	input  logic [TOTAL_BITS-1:0] total_i,
	input  logic [TOTAL_BITS-1:0] total_j,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_BITS-1:0]   dissimilarity
);

	pjsd_cmd_t cmd;
	pjsd_sts_t sts;

	pjsd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	pjsd_datapath #(.AREA_BITS(AREA_BITS), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.area_i(area_i), .area_j(area_j), .total_i(total_i), .total_j(total_j),
		.last(last), .result(dissimilarity)
	);

	a_one_hi: assert property (@(posedge clk) disable iff (!arst_n)
		dissimilarity <= ONE_OUT) else $error("result above one");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.acc_add && cmd.acc_sub)) else $error("add and subtract together");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result waits");

endmodule

### sim/pjsd_checker.sv
// pjsd_checker: watches both channels of the pair dissimilarity block, predicts and compares
// depends on pjsd_pkg for the field widths
`timescale 1ns / 1ps

module pjsd_checker
	import pjsd_pkg::*;
#(
	parameter int AREA_BITS = AREA_BITS_DEF,
	parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [AREA_BITS-1:0]  area_i,
	input  logic [AREA_BITS-1:0]  area_j,
	input  logic [TOTAL_BITS-1:0] total_i,
	input  logic [TOTAL_BITS-1:0] total_j,
	input  logic                  last,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [OUT_BITS-1:0]   dissimilarity,
	output int                    fail_count,
	output int                    pending
);

	logic [63:0] entropy_sum;
	logic [OUT_BITS-1:0] expected_dissim[$];

	function automatic logic [63:0] log2_fixed(input logic [63:0] x);
		int n;
		logic [63:0] y;
		logic [63:0] frac;
		n = 0;
		frac = '0;
		if (x == 0)
			return '0;
		while (n < 63 && (x >> (n + 1)) != 0)
			n++;
		if (n <= 31)
			y = x << (31 - n);
		else
			y = x >> (n - 31);
		for (int k = 0; k < LOG_FRAC_BITS; k++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				y = y >> 1;
			end
		end
		return (64'(n) << LOG_FRAC_BITS) | frac;
	endfunction

	function automatic logic [63:0] entropy_term(input logic [63:0] a, input logic [63:0] s);
		logic signed [63:0] d;
		if (a == 0)
			return '0;
		d = $signed(log2_fixed(a)) - $signed(log2_fixed(s));
		return $signed(a) * d;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	assign pending = expected_dissim.size();

	initial begin
		fail_count = 0;
		entropy_sum = '0;
	end

	// sample at the falling edge; a transfer happens at the following rising edge
	always @(negedge clk) begin
		logic [63:0] tij;
		logic [63:0] q;
		logic [63:0] res;
		if (!arst_n) begin
			entropy_sum = '0;
		end else begin
			if (in_valid && !in_stall) begin
				tij = 64'(total_i) + 64'(total_j);
				entropy_sum = entropy_sum - entropy_term(64'(area_i) + 64'(area_j), tij);
				entropy_sum = entropy_sum + entropy_term(64'(area_i), 64'(total_i));
				entropy_sum = entropy_sum + entropy_term(64'(area_j), 64'(total_j));
				if (last) begin
					res = '0;
					if (tij != 0 && !entropy_sum[63] && entropy_sum != 0) begin
						q = entropy_sum / tij;
						if (LOG_FRAC_BITS >= OUT_FRAC_BITS)
							res = q >> (LOG_FRAC_BITS - OUT_FRAC_BITS);
						else if (q >= 64'h100_0000_0000)
							res = 64'(ONE_OUT);
						else
							res = q << (OUT_FRAC_BITS - LOG_FRAC_BITS);
						if (res > 64'(ONE_OUT))
							res = 64'(ONE_OUT);
					end
					expected_dissim = {expected_dissim, res[OUT_BITS-1:0]};
					entropy_sum = '0;
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_dissim.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d", dissimilarity));
				end else begin
					if (dissimilarity !== expected_dissim[0])
						report_mismatch($sformatf("dissimilarity got %0d want %0d",
							dissimilarity, expected_dissim[0]));
					void'(expected_dissim.pop_front());
				end
			end
		end
	end

endmodule

### sim/tb_polygon_pair_js_dissimilarity.sv
// tb_polygon_pair_js_dissimilarity: drives viewpoint runs into the pair dissimilarity block
// depends on pjsd_pkg, pjsd_checker and the polygon_pair_js_dissimilarity rtl
`timescale 1ns / 1ps

module tb_polygon_pair_js_dissimilarity
	import pjsd_pkg::*;
();

	localparam int AREA_BITS = AREA_BITS_DEF;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [AREA_BITS-1:0] area_i;
	logic [AREA_BITS-1:0] area_j;
	logic [TOTAL_BITS-1:0] total_i;
	logic [TOTAL_BITS-1:0] total_j;
	logic last;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_BITS-1:0] dissimilarity;
	int fail_count;
	int pending;
	int cycle_count = 0;
	int send_idle_pct;
	int recv_stall_pct;
	int viewpoints_sent;

	polygon_pair_js_dissimilarity u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.area_i(area_i), .area_j(area_j), .total_i(total_i), .total_j(total_j),
		.last(last),
		.out_valid(out_valid), .out_stall(out_stall), .dissimilarity(dissimilarity)
	);

	pjsd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.area_i(area_i), .area_j(area_j), .total_i(total_i), .total_j(total_j),
		.last(last),
		.out_valid(out_valid), .out_stall(out_stall), .dissimilarity(dissimilarity),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_viewpoint(input logic [AREA_BITS-1:0] ai, input logic [AREA_BITS-1:0] aj,
			input logic [TOTAL_BITS-1:0] ti, input logic [TOTAL_BITS-1:0] tj, input logic lst);
		logic go;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			area_i <= AREA_BITS'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		area_i <= ai;
		area_j <= aj;
		total_i <= ti;
		total_j <= tj;
		last <= lst;
		do begin
			@(negedge clk);
			go = !in_stall;
			@(posedge clk);
		end while (!go);
		viewpoints_sent++;
		if (viewpoints_sent == 140) begin
			send_idle_pct = 48;
			recv_stall_pct = 28;
		end else if (viewpoints_sent == 280) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	endtask

	// a run of n viewpoints; consistent runs use totals equal to the area sums
	task automatic send_pair_run(input int n, input bit consistent);
		logic [AREA_BITS-1:0] ai[$];
		logic [AREA_BITS-1:0] aj[$];
		logic [TOTAL_BITS-1:0] ti;
		logic [TOTAL_BITS-1:0] tj;
		logic [AREA_BITS-1:0] va;
		logic [AREA_BITS-1:0] vb;
		ti = '0;
		tj = '0;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: va = '0;
				1: va = AREA_BITS'($urandom_range(1, 255));
				default: va = AREA_BITS'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: vb = '0;
				1: vb = AREA_BITS'($urandom_range(1, 255));
				default: vb = AREA_BITS'($urandom);
			endcase
			ai = {ai, va};
			aj = {aj, vb};
			ti = ti + TOTAL_BITS'(va);
			tj = tj + TOTAL_BITS'(vb);
		end
		if (!consistent) begin
			ti = TOTAL_BITS'($urandom);
			tj = ($urandom_range(0, 3) == 0) ? '0 : TOTAL_BITS'($urandom);
		end
		for (int k = 0; k < n; k++)
			send_viewpoint(ai[k], aj[k], ti, tj, k == n - 1);
	endtask

	localparam logic [AREA_BITS-1:0] AMAX = '1;
	localparam logic [TOTAL_BITS-1:0] TMAX = '1;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		area_i = '0;
		area_j = '0;
		total_i = '0;
		total_j = '0;
		last = 1'b0;
		viewpoints_sent = 0;
		send_idle_pct = 28;
		recv_stall_pct = 48;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// combined total zero
		send_viewpoint('0, '0, '0, '0, 1'b1);
		send_viewpoint(AREA_BITS'(5), AREA_BITS'(9), '0, '0, 1'b1);
		// area nonzero with its total zero
		send_viewpoint(AMAX, '0, '0, TOTAL_BITS'(100), 1'b1);
		send_viewpoint(AREA_BITS'(1), AMAX, TOTAL_BITS'(3), '0, 1'b1);
		// field extremes, saturation and negative sums
		send_viewpoint(AMAX, AMAX, TMAX, TMAX, 1'b1);
		send_viewpoint(AMAX, '0, TOTAL_BITS'(1), TOTAL_BITS'(1), 1'b1);
		send_viewpoint('0, AMAX, TOTAL_BITS'(1), TOTAL_BITS'(1), 1'b1);
		send_viewpoint(AREA_BITS'(1), AREA_BITS'(1), TMAX, TOTAL_BITS'(1), 1'b1);
		send_viewpoint(AMAX, AREA_BITS'(1), TOTAL_BITS'(AMAX), TOTAL_BITS'(1), 1'b0);
		send_viewpoint(AREA_BITS'(1), AMAX, TOTAL_BITS'(AMAX), TOTAL_BITS'(1), 1'b1);
		// disjoint polygons give full divergence
		send_viewpoint(AREA_BITS'(1000), '0, TOTAL_BITS'(1000), TOTAL_BITS'(1000), 1'b0);
		send_viewpoint('0, AREA_BITS'(1000), TOTAL_BITS'(1000), TOTAL_BITS'(1000), 1'b1);
		// identical polygons give zero
		send_viewpoint(AREA_BITS'(300), AREA_BITS'(300), TOTAL_BITS'(700), TOTAL_BITS'(700),
			1'b0);
		send_viewpoint(AREA_BITS'(400), AREA_BITS'(400), TOTAL_BITS'(700), TOTAL_BITS'(700),
			1'b1);
		send_pair_run(4, 1'b1);

		while (viewpoints_sent < 390) begin
			if ($urandom_range(0, 9) < 7)
				send_pair_run($urandom_range(1, 6), 1'b1);
			else
				send_pair_run($urandom_range(1, 4), 1'b0);
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
